// ===== hdl/rsw_pkg.sv =====
// Shared types and constants for the RGBA32 rotate and swizzle block.
// Holds the configuration record, register map, rotation codes and reset values.
// No dependencies.
`default_nettype none

package rsw_pkg;

    localparam int PIXEL_W     = 32;
    localparam int BYTE_W      = 8;
    localparam int LANES       = PIXEL_W / BYTE_W;
    localparam int LANE_SEL_W  = $clog2(LANES);
    localparam int POS_W       = 12;
    localparam int CFG_SIZE_W  = 13;
    localparam int ROT_W       = 2;
    localparam int SWZ_W       = 26;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int MIN_HEIGHT  = 4;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam logic [CFG_SIZE_W-1:0] RST_FRAME_WIDTH  = CFG_SIZE_W'(1);
    localparam logic [CFG_SIZE_W-1:0] RST_FRAME_HEIGHT = CFG_SIZE_W'(4);
    localparam logic [SWZ_W-1:0]      RST_SWIZZLE      = SWZ_W'(32'h0302_0100);

    typedef enum logic [ROT_W-1:0] {
        ROT_NONE = 2'd0,
        ROT_90   = 2'd1,
        ROT_180  = 2'd2,
        ROT_270  = 2'd3
    } rot_t;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_ROTATION     = 2'd2,
        REG_SWIZZLE      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_SIZE_W-1:0] frame_width;
        logic [CFG_SIZE_W-1:0] frame_height;
        rot_t                  rotation;
        logic [SWZ_W-1:0]      swizzle;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/rsw_cfg_regs.sv =====
// APB configuration registers and clamped frame size for the rotate block.
// Depends on rsw_pkg.
`default_nettype none

module rsw_cfg_regs #(
    parameter int MAX_WIDTH  = rsw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rsw_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rsw_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [rsw_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [rsw_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output rsw_pkg::cfg_t                       cfg,
    output logic [$clog2(MAX_WIDTH+1)-1:0]      width_eff,
    output logic [$clog2(MAX_HEIGHT+1)-1:0]     height_eff
);
    import rsw_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width  <= RST_FRAME_WIDTH;
            cfg_reg.frame_height <= RST_FRAME_HEIGHT;
            cfg_reg.rotation     <= ROT_NONE;
            cfg_reg.swizzle      <= RST_SWIZZLE;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= pwdata[CFG_SIZE_W-1:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= pwdata[CFG_SIZE_W-1:0];
                REG_ROTATION:     cfg_reg.rotation     <= rot_t'(pwdata[ROT_W-1:0]);
                REG_SWIZZLE:      cfg_reg.swizzle      <= pwdata[SWZ_W-1:0];
                default:          cfg_reg.swizzle      <= cfg_reg.swizzle;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(cfg_reg.frame_height);
            REG_ROTATION:     prdata = APB_DATA_W'(cfg_reg.rotation);
            REG_SWIZZLE:      prdata = APB_DATA_W'(cfg_reg.swizzle);
            default:          prdata = '0;
        endcase
    end

    // Out-of-range sizes act as the nearest legal size.
    always_comb begin
        if (cfg_reg.frame_width == '0) begin
            width_eff = WW'(1);
        end else if (32'(cfg_reg.frame_width) > MAX_WIDTH) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(cfg_reg.frame_width);
        end

        if (32'(cfg_reg.frame_height) < MIN_HEIGHT) begin
            height_eff = HW'(MIN_HEIGHT);
        end else if (32'(cfg_reg.frame_height) > MAX_HEIGHT) begin
            height_eff = HW'(MAX_HEIGHT);
        end else begin
            height_eff = HW'(cfg_reg.frame_height);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rsw_pos_counter.sv =====
// Source column/row counter in raster order, wrapping at the frame size.
// Depends on rsw_pkg.
`default_nettype none

module rsw_pos_counter #(
    parameter int MAX_WIDTH  = rsw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rsw_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                advance,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      width_eff,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]     height_eff,
    output logic [$clog2(MAX_WIDTH)-1:0]        col,
    output logic [$clog2(MAX_HEIGHT)-1:0]       row,
    output logic                                frame_end
);
    import rsw_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          last_col, last_row;

    // A counter at or past its limit (size changed mid-frame) counts as the last one.
    assign last_col  = (32'(col_reg) + 32'd1) >= 32'(width_eff);
    assign last_row  = (32'(row_reg) + 32'd1) >= 32'(height_eff);
    assign frame_end = last_col && last_row;
    assign col       = col_reg;
    assign row       = row_reg;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rsw_xform.sv =====
// Destination address under rotation and byte lane swizzle for one pixel.
// Pure combinational; depends on rsw_pkg.
`default_nettype none

module rsw_xform #(
    parameter int MAX_WIDTH  = rsw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rsw_pkg::DEF_MAX_HEIGHT
) (
    input  rsw_pkg::cfg_t                       cfg,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      width_eff,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]     height_eff,
    input  logic [$clog2(MAX_WIDTH)-1:0]        col,
    input  logic [$clog2(MAX_HEIGHT)-1:0]       row,
    input  logic [rsw_pkg::PIXEL_W-1:0]         pixel_in,
    output logic [rsw_pkg::POS_W-1:0]           dest_row,
    output logic [rsw_pkg::POS_W-1:0]           dest_col,
    output logic [rsw_pkg::CFG_SIZE_W-1:0]      dest_line_width,
    output logic [rsw_pkg::PIXEL_W-1:0]         pixel_out
);
    import rsw_pkg::*;

    logic [POS_W-1:0] x, y, w_m1, h_m1;

    // Addresses wrap modulo 4096, matching the 12-bit outputs.
    assign x    = POS_W'(col);
    assign y    = POS_W'(row);
    assign w_m1 = POS_W'(width_eff) - POS_W'(1);
    assign h_m1 = POS_W'(height_eff) - POS_W'(1);

    always_comb begin
        unique case (cfg.rotation)
            ROT_90: begin
                dest_row        = x;
                dest_col        = h_m1 - y;
                dest_line_width = CFG_SIZE_W'(height_eff);
            end
            ROT_180: begin
                dest_row        = h_m1 - y;
                dest_col        = w_m1 - x;
                dest_line_width = CFG_SIZE_W'(width_eff);
            end
            ROT_270: begin
                dest_row        = w_m1 - x;
                dest_col        = y;
                dest_line_width = CFG_SIZE_W'(height_eff);
            end
            default: begin
                dest_row        = y;
                dest_col        = x;
                dest_line_width = CFG_SIZE_W'(width_eff);
            end
        endcase
    end

    // Each source byte lands on the lane named by its mask field; collisions OR.
    always_comb begin
        logic [LANE_SEL_W-1:0] lane;
        pixel_out = '0;
        for (int i = 0; i < LANES; i++) begin
            lane = cfg.swizzle[BYTE_W*i +: LANE_SEL_W];
            for (int j = 0; j < LANES; j++) begin
                if (lane == LANE_SEL_W'(j)) begin
                    pixel_out[BYTE_W*j +: BYTE_W] = pixel_out[BYTE_W*j +: BYTE_W]
                                                  | pixel_in[BYTE_W*i +: BYTE_W];
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rotate_and_swizzle_rgba32_pixels.sv =====
// Streaming RGBA32 rotator: destination address and byte swizzle per pixel.
// Top level; depends on rsw_pkg, rsw_cfg_regs, rsw_pos_counter, rsw_xform.
//
// Usage:
//   Source pixels enter on the s_ channel (valid/ready) in raster order; one
//   result item per pixel leaves on the m_ channel with destination row and
//   column, destination line width, swizzled pixel and a last-of-frame mark.
//   Frame size, rotation and swizzle mask are set over the APB port; the user
//   is to set them only while the stream is idle, as the block has no check
//   for it; pready is always high. Path: an accepted item enters the input
//   register, then, once the result side can take it, the result register,
//   which drives m_valid. Throughput: one item per clock while m_ready
//   stays high; the only logic between the two registers is the address
//   subtract/select and the byte lane OR network.
//   Stall: with m_ready low and a result waiting, the result register holds;
//   an empty input register still takes one more item, after which s_ready
//   drops until m_ready returns. s_ready follows m_ready combinationally.
//   Reset (aresetn low, synchronous): pipeline empties, column and row
//   counters return to zero, registers take width 1, height 4, no rotation
//   and the identity swizzle.
`default_nettype none

module rotate_and_swizzle_rgba32_pixels #(
    parameter int MAX_WIDTH  = rsw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rsw_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rsw_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [rsw_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [rsw_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rsw_pkg::PIXEL_W-1:0]         s_pixel_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rsw_pkg::POS_W-1:0]           m_dest_row,
    output logic [rsw_pkg::POS_W-1:0]           m_dest_col,
    output logic [rsw_pkg::CFG_SIZE_W-1:0]      m_dest_line_width,
    output logic [rsw_pkg::PIXEL_W-1:0]         m_pixel_out,
    output logic                                m_frame_end
);
    import rsw_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    cfg_t            cfg;
    logic [WW-1:0]   width_eff;
    logic [HW-1:0]   height_eff;
    logic [CW-1:0]   cur_col;
    logic [RW-1:0]   cur_row;
    logic            cur_frame_end;

    // input stage
    logic                a_valid_reg;
    logic [PIXEL_W-1:0]  a_pixel_reg;
    logic [CW-1:0]       a_col_reg;
    logic [RW-1:0]       a_row_reg;
    logic                a_frame_end_reg;

    // result stage
    logic                   m_valid_reg;
    logic [POS_W-1:0]       m_dest_row_reg;
    logic [POS_W-1:0]       m_dest_col_reg;
    logic [CFG_SIZE_W-1:0]  m_line_reg;
    logic [PIXEL_W-1:0]     m_pixel_reg;
    logic                   m_frame_end_reg;

    logic [POS_W-1:0]       x_dest_row;
    logic [POS_W-1:0]       x_dest_col;
    logic [CFG_SIZE_W-1:0]  x_line;
    logic [PIXEL_W-1:0]     x_pixel;

    logic in_take, b_ready, b_load;

    assign b_ready = !m_valid_reg || m_ready;
    assign s_ready = !a_valid_reg || b_ready;
    assign in_take = s_valid && s_ready;
    assign b_load  = a_valid_reg && b_ready;

    rsw_cfg_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cfg        (cfg),
        .width_eff  (width_eff),
        .height_eff (height_eff)
    );

    rsw_pos_counter #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (in_take),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .col        (cur_col),
        .row        (cur_row),
        .frame_end  (cur_frame_end)
    );

    rsw_xform #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_xform (
        .cfg             (cfg),
        .width_eff       (width_eff),
        .height_eff      (height_eff),
        .col             (a_col_reg),
        .row             (a_row_reg),
        .pixel_in        (a_pixel_reg),
        .dest_row        (x_dest_row),
        .dest_col        (x_dest_col),
        .dest_line_width (x_line),
        .pixel_out       (x_pixel)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                a_valid_reg <= s_valid;
            end
            if (b_ready) begin
                m_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            a_pixel_reg     <= s_pixel_in;
            a_col_reg       <= cur_col;
            a_row_reg       <= cur_row;
            a_frame_end_reg <= cur_frame_end;
        end
        if (b_load) begin
            m_dest_row_reg  <= x_dest_row;
            m_dest_col_reg  <= x_dest_col;
            m_line_reg      <= x_line;
            m_pixel_reg     <= x_pixel;
            m_frame_end_reg <= a_frame_end_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_dest_row        = m_dest_row_reg;
    assign m_dest_col        = m_dest_col_reg;
    assign m_dest_line_width = m_line_reg;
    assign m_pixel_out       = m_pixel_reg;
    assign m_frame_end       = m_frame_end_reg;

endmodule

`default_nettype wire

// ===== hdl/rsw_checker.sv =====
// Port-level checks for the rotate and swizzle block, bound to its top level.
// Depends on rotate_and_swizzle_rgba32_pixels and rsw_pkg.
`default_nettype none

module rsw_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [rsw_pkg::PIXEL_W-1:0]         m_pixel_out,
    input logic [rsw_pkg::CFG_SIZE_W-1:0]      m_dest_line_width
);

    // Pipeline is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Input only backs up when the result side is full and stalled.
    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a stalled result");

    // A result item always carries a nonzero line width.
    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_dest_line_width != '0))
        else $error("zero destination line width");

    // A stalled result holds its item.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pixel_out)
                                   && $stable(m_dest_line_width)))
        else $error("stalled result changed");

endmodule

bind rotate_and_swizzle_rgba32_pixels rsw_checker u_rsw_checker (.*);

`default_nettype wire

// ===== verif/rotate_and_swizzle_rgba32_pixels_test.sv =====
// Self-checking testbench for the RGBA32 rotate and swizzle block.
// Depends on rsw_pkg and rotate_and_swizzle_rgba32_pixels; a directed table, then random
// frames with random idling, checked against an in-bench address and swizzle predictor.
module rotate_and_swizzle_rgba32_pixels_test;
    import rsw_pkg::*;

    localparam int NUM_PHASES     = 10;
    localparam int PHASE_ITEMS    = 80;
    localparam int PRESSURE_PHASE = 3;
    localparam int HOLD_CYCLES    = 200;
    localparam int PLAN_LEN       = 34;

    typedef struct packed {
        logic [POS_W-1:0]      dest_row;
        logic [POS_W-1:0]      dest_col;
        logic [CFG_SIZE_W-1:0] line_width;
        logic [PIXEL_W-1:0]    pixel;
        logic                  frame_end;
    } rot_result_t;

    typedef struct packed {
        logic        is_reg;
        reg_idx_t    idx;
        logic [31:0] data;
        logic        known;
        rot_result_t want;
    } plan_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic               s_valid    = 1'b0;
    logic               s_ready;
    logic [PIXEL_W-1:0] s_pixel_in = '0;

    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [POS_W-1:0]      m_dest_row;
    logic [POS_W-1:0]      m_dest_col;
    logic [CFG_SIZE_W-1:0] m_dest_line_width;
    logic [PIXEL_W-1:0]    m_pixel_out;
    logic                  m_frame_end;

    // directed rows with a hand-computed result ride along with the item
    logic        known_flag = 1'b0;
    rot_result_t known_want = '0;

    bit tx_idle  = 1'b1;
    bit rx_idle  = 1'b1;
    bit hold_req = 1'b0;
    int errors   = 0;

    // predictor copy of the registers and the source position
    logic [CFG_SIZE_W-1:0] cfg_width  = RST_FRAME_WIDTH;
    logic [CFG_SIZE_W-1:0] cfg_height = RST_FRAME_HEIGHT;
    rot_t                  cfg_rot    = ROT_NONE;
    logic [SWZ_W-1:0]      cfg_swz    = RST_SWIZZLE;
    int                    src_col    = 0;
    int                    src_row    = 0;

    rot_result_t expected_pixels [$];

    rotate_and_swizzle_rgba32_pixels dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pixel_in        (s_pixel_in),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_dest_row        (m_dest_row),
        .m_dest_col        (m_dest_col),
        .m_dest_line_width (m_dest_line_width),
        .m_pixel_out       (m_pixel_out),
        .m_frame_end       (m_frame_end)
    );

    always #5 aclk = ~aclk;

    function automatic plan_row_t pix_row(logic [31:0] px);
        plan_row_t r;
        r        = '0;
        r.idx    = REG_FRAME_WIDTH;
        r.data   = px;
        return r;
    endfunction

    function automatic plan_row_t pix_known(logic [31:0] px, int row, int col, int line,
                                            logic [31:0] out, logic fe);
        plan_row_t r;
        r                 = pix_row(px);
        r.known           = 1'b1;
        r.want.dest_row   = POS_W'(row);
        r.want.dest_col   = POS_W'(col);
        r.want.line_width = CFG_SIZE_W'(line);
        r.want.pixel      = out;
        r.want.frame_end  = fe;
        return r;
    endfunction

    function automatic plan_row_t reg_row(reg_idx_t idx, logic [31:0] v);
        plan_row_t r;
        r        = '0;
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.data   = v;
        return r;
    endfunction

    plan_row_t directed_plan [PLAN_LEN] = '{
        // reset setting: one column, four rows, identity swizzle
        pix_known(32'h0000_0000, 0, 0, 1, 32'h0000_0000, 1'b0),
        pix_known(32'hFFFF_FFFF, 1, 0, 1, 32'hFFFF_FFFF, 1'b0),
        pix_known(32'h1234_5678, 2, 0, 1, 32'h1234_5678, 1'b0),
        pix_known(32'h8000_0001, 3, 0, 1, 32'h8000_0001, 1'b1),
        // byte reversal, 4x4, each rotation in turn along the first line
        reg_row(REG_SWIZZLE, 32'h0001_0203),
        reg_row(REG_FRAME_WIDTH, 32'd4),
        reg_row(REG_ROTATION, 32'(ROT_90)),
        pix_known(32'h1122_3344, 0, 3, 4, 32'h4433_2211, 1'b0),
        reg_row(REG_ROTATION, 32'(ROT_180)),
        pix_known(32'h0102_0304, 3, 2, 4, 32'h0403_0201, 1'b0),
        reg_row(REG_ROTATION, 32'(ROT_270)),
        pix_known(32'hA5A5_A5A5, 1, 0, 4, 32'hA5A5_A5A5, 1'b0),
        // all bytes to lane 0: they OR together
        reg_row(REG_SWIZZLE, 32'h0000_0000),
        pix_known(32'h0102_0408, 0, 0, 4, 32'h0000_000F, 1'b0),
        // upper mask bits set in the three lower bytes, only the low two count
        reg_row(REG_SWIZZLE, 32'h03FC_FDFE),
        pix_row(32'hDEAD_BEEF),
        // sizes below range clamp up
        reg_row(REG_FRAME_WIDTH, 32'd0),
        reg_row(REG_FRAME_HEIGHT, 32'd0),
        reg_row(REG_ROTATION, 32'(ROT_NONE)),
        pix_row(32'h0000_0000),
        pix_row(32'hFFFF_FFFF),
        // sizes above range clamp down, destinations at the far columns under 180
        reg_row(REG_FRAME_WIDTH, 32'h1FFF),
        reg_row(REG_FRAME_HEIGHT, 32'h1FFF),
        reg_row(REG_ROTATION, 32'(ROT_180)),
        pix_row(32'h5A5A_5A5A),
        pix_row(32'hC3C3_3C3C),
        pix_row(32'h0F0F_F0F0),
        // shrink mid-line: column past the new width
        reg_row(REG_FRAME_WIDTH, 32'd2),
        pix_row(32'h7FFF_FFFE),
        pix_row(32'h8000_0000),
        reg_row(REG_FRAME_HEIGHT, 32'd4096),
        reg_row(REG_FRAME_WIDTH, 32'd4096),
        reg_row(REG_ROTATION, 32'(ROT_90)),
        pix_row(32'h0000_0001)
    };

    // destination of the next source pixel; advances the source position
    function automatic rot_result_t next_rotated_pixel(logic [PIXEL_W-1:0] px);
        rot_result_t r;
        int w, h, x, y, row, col, line, lane;
        logic [PIXEL_W-1:0] out;
        w = int'(cfg_width);
        h = int'(cfg_height);
        if (w < 1) w = 1;
        if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
        if (h < MIN_HEIGHT) h = MIN_HEIGHT;
        if (h > DEF_MAX_HEIGHT) h = DEF_MAX_HEIGHT;
        x = src_col;
        y = src_row;
        case (cfg_rot)
            ROT_90: begin
                row = x; col = h - 1 - y; line = h;
            end
            ROT_180: begin
                row = h - 1 - y; col = w - 1 - x; line = w;
            end
            ROT_270: begin
                row = w - 1 - x; col = y; line = h;
            end
            default: begin
                row = y; col = x; line = w;
            end
        endcase
        out = '0;
        for (int i = 0; i < LANES; i++) begin
            lane = int'(cfg_swz[BYTE_W*i +: LANE_SEL_W]);
            out[BYTE_W*lane +: BYTE_W] = out[BYTE_W*lane +: BYTE_W] | px[BYTE_W*i +: BYTE_W];
        end
        // negative coordinates after a mid-frame shrink wrap modulo 4096
        r.dest_row   = row[POS_W-1:0];
        r.dest_col   = col[POS_W-1:0];
        r.line_width = line[CFG_SIZE_W-1:0];
        r.pixel      = out;
        r.frame_end  = (x >= w - 1) && (y >= h - 1);
        if (x >= w - 1) begin
            src_col = 0;
            src_row = (y >= h - 1) ? 0 : y + 1;
        end else begin
            src_col = x + 1;
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t %s: expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        rot_result_t want;
        if (aresetn) begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_FRAME_WIDTH:  cfg_width  = pwdata[CFG_SIZE_W-1:0];
                    REG_FRAME_HEIGHT: cfg_height = pwdata[CFG_SIZE_W-1:0];
                    REG_ROTATION:     cfg_rot    = rot_t'(pwdata[ROT_W-1:0]);
                    REG_SWIZZLE:      cfg_swz    = pwdata[SWZ_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                want = next_rotated_pixel(s_pixel_in);
                if (known_flag) want = known_want;
                expected_pixels.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    errors++;
                    $display("%0t unexpected item: row %h col %h pixel %h", $time,
                             m_dest_row, m_dest_col, m_pixel_out);
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("dest_row", 32'(want.dest_row), 32'(m_dest_row));
                    check_field("dest_col", 32'(want.dest_col), 32'(m_dest_col));
                    check_field("dest_line_width", 32'(want.line_width),
                                32'(m_dest_line_width));
                    check_field("pixel_out", want.pixel, m_pixel_out);
                    check_field("frame_end", 32'(want.frame_end), 32'(m_frame_end));
                end
            end
        end
    end

    // result side: random stalls, one long hold-off when asked
    initial begin
        int stall;
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            stall = rx_idle ? $urandom_range(0, 19) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic apb_write(reg_idx_t idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic offer_pixel(logic [31:0] px, logic known, rot_result_t want);
        int gap;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_pixel_in <= px;
        known_flag <= known;
        known_want <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_pixels.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int w, h, pick;
        logic [31:0] swz, px;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_reg) begin
                wait_drained();
                apb_write(directed_plan[i].idx, directed_plan[i].data);
            end else begin
                offer_pixel(directed_plan[i].data, directed_plan[i].known,
                            directed_plan[i].want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            pick = $urandom_range(0, 9);
            if (pick <= 5) w = $urandom_range(1, 6);
            else if (pick == 6) w = 0;
            else if (pick == 7) w = DEF_MAX_WIDTH;
            else if (pick == 8) w = 8191;
            else w = $urandom_range(1, 8191);
            pick = $urandom_range(0, 9);
            if (pick <= 5) h = $urandom_range(4, 8);
            else if (pick == 6) h = $urandom_range(0, 3);
            else if (pick == 7) h = DEF_MAX_HEIGHT;
            else if (pick == 8) h = 8191;
            else h = $urandom_range(0, 8191);
            // pin the smallest and largest frames once each
            if (ph == 0) begin
                w = 1;
                h = MIN_HEIGHT;
            end else if (ph == 1) begin
                w = DEF_MAX_WIDTH;
                h = DEF_MAX_HEIGHT;
            end
            pick = $urandom_range(0, 3);
            if (pick <= 1) swz = $urandom() & 32'h03FF_FFFF;
            else if (pick == 2) swz = 32'(RST_SWIZZLE);
            else swz = {4{6'b0, 2'($urandom_range(0, 3))}} & 32'h03FF_FFFF;
            apb_write(REG_FRAME_WIDTH, 32'(w));
            apb_write(REG_FRAME_HEIGHT, 32'(h));
            apb_write(REG_ROTATION, 32'($urandom_range(0, 3)));
            apb_write(REG_SWIZZLE, swz);

            tx_idle = $urandom_range(0, 1);
            rx_idle = $urandom_range(0, 1);
            if (ph == PRESSURE_PHASE) begin
                // back-to-back items into a stalled receiver
                tx_idle  = 1'b0;
                rx_idle  = 1'b0;
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 15);
                if (pick == 0) px = 32'h0000_0000;
                else if (pick == 1) px = 32'hFFFF_FFFF;
                else px = $urandom();
                offer_pixel(px, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (4) @(posedge aclk);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/rsw_pkg.sv
hdl/rsw_cfg_regs.sv
hdl/rsw_pos_counter.sv
hdl/rsw_xform.sv
hdl/rotate_and_swizzle_rgba32_pixels.sv
hdl/rsw_checker.sv
verif/rotate_and_swizzle_rgba32_pixels_test.sv
